### hdl/aes_key_schedule_128_256_assert.svh
// Assertion macros for the key schedule block.
// Both expect clk_i and rst_ni in scope.
`ifndef AES_KEY_SCHEDULE_128_256_ASSERT_SVH
`define AES_KEY_SCHEDULE_128_256_ASSERT_SVH

// Checked out of reset only.
`define AKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define AKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/aks_pkg.sv
`default_nettype none

package aks_pkg;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } aks_state_e;

  typedef logic [31:0] word_t;

  // Key variant codes
  localparam logic VARIANT_128 = 1'b0;
  localparam logic VARIANT_256 = 1'b1;

  // Index of the final schedule word per variant
  localparam logic [5:0] LAST_IDX_128 = 6'd43;
  localparam logic [5:0] LAST_IDX_256 = 6'd59;

  // Highest word position within one key block per variant
  localparam logic [2:0] POS_MAX_128 = 3'd3;
  localparam logic [2:0] POS_MAX_256 = 3'd7;

  // Position within the block that gets the plain substitution (AES-256)
  localparam logic [2:0] POS_SUB_ONLY = 3'd4;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // SubWord: S-box on each byte
  function automatic word_t sbox_subst(input word_t x);
    sbox_subst = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // Round constant for round k; zero outside 1..10
  function automatic word_t rcon(input logic [3:0] k);
    case (k)
      4'd1:    rcon = 32'h0100_0000;
      4'd2:    rcon = 32'h0200_0000;
      4'd3:    rcon = 32'h0400_0000;
      4'd4:    rcon = 32'h0800_0000;
      4'd5:    rcon = 32'h1000_0000;
      4'd6:    rcon = 32'h2000_0000;
      4'd7:    rcon = 32'h4000_0000;
      4'd8:    rcon = 32'h8000_0000;
      4'd9:    rcon = 32'h1b00_0000;
      4'd10:   rcon = 32'h3600_0000;
      default: rcon = 32'h0000_0000;
    endcase
  endfunction

endpackage

`default_nettype wire

### hdl/aes_key_schedule_128_256.sv
`default_nettype none
// A taken key is loaded into the word window and starts the word sequencer; each schedule word
// is then registered in the output register. Throughput: one word per cycle, set by the single
// shared SubWord unit that produces one schedule word per cycle. No new key is taken until
// the last word; output stalls pause the word sequencer and lengthen the item.
// Reset (rst_ni low, asynchronous) returns the block to idle, empties the output
// register and selects AES-128.
module aes_key_schedule_128_256 (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration: key_variant
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic                  cfg_data_i,
  // key input
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [63:0]           key_bytes_0_7_i,
  input  wire logic [63:0]           key_bytes_8_15_i,
  input  wire logic [63:0]           key_bytes_16_23_i,
  input  wire logic [63:0]           key_bytes_24_31_i,
  // schedule output
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      aks_pkg::word_t        round_key_word_o,
  output      logic [5:0]            word_index_o,
  output      logic                  last_word_o
);
  import aks_pkg::*;

  aks_state_e state_q, state_d;
  logic       variant_q;
  word_t      win_q [8];
  word_t      win_d [8];
  logic [5:0] idx_q, idx_d;
  logic [2:0] pos_q, pos_d;
  logic [3:0] rnd_q, rnd_d;
  logic       out_valid_q, out_valid_d;
  word_t      out_word_q;
  logic [5:0] out_idx_q;
  logic       out_last_q;

  logic       in_acc;
  logic       adv;
  logic       is_last;
  logic [2:0] pos_max;
  word_t      prev_w;
  word_t      sub_in;
  word_t      sub_out;
  word_t      xform;
  word_t      new_w;

  // Config register, written while idle
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VARIANT_128;
    end else if (cfg_valid_i && cfg_ready_o) begin
      variant_q <= cfg_data_i;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // One word per cycle while running and the output register can take it
  assign adv     = (state_q == ST_RUN) && (!out_valid_q || !out_stall_i);
  assign pos_max = (variant_q == VARIANT_256) ? POS_MAX_256 : POS_MAX_128;
  assign is_last = (idx_q == ((variant_q == VARIANT_256) ? LAST_IDX_256 : LAST_IDX_128));

  // Shared SubWord unit; window holds w[i] .. w[i+Nk-1], new word is w[i+Nk]
  assign prev_w  = win_q[pos_max];
  assign sub_in  = (pos_q == 3'd0) ? {prev_w[23:0], prev_w[31:24]} : prev_w;
  assign sub_out = sbox_subst(sub_in);

  always_comb begin
    if (pos_q == 3'd0) begin
      xform = sub_out ^ rcon(rnd_q + 4'd1);
    end else if ((variant_q == VARIANT_256) && (pos_q == POS_SUB_ONLY)) begin
      xform = sub_out;
    end else begin
      xform = prev_w;
    end
  end

  assign new_w = win_q[0] ^ xform;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q;
    for (int k = 0; k < 8; k++) begin
      win_d[k] = win_q[k];
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d  = ST_RUN;
          idx_d    = 6'd0;
          pos_d    = 3'd0;
          rnd_d    = 4'd0;
          win_d[0] = key_bytes_0_7_i[63:32];
          win_d[1] = key_bytes_0_7_i[31:0];
          win_d[2] = key_bytes_8_15_i[63:32];
          win_d[3] = key_bytes_8_15_i[31:0];
          win_d[4] = key_bytes_16_23_i[63:32];
          win_d[5] = key_bytes_16_23_i[31:0];
          win_d[6] = key_bytes_24_31_i[63:32];
          win_d[7] = key_bytes_24_31_i[31:0];
        end
      end
      ST_RUN: begin
        if (adv) begin
          out_valid_d = 1'b1;
          idx_d       = idx_q + 6'd1;
          for (int k = 0; k < 7; k++) begin
            win_d[k] = win_q[k + 1];
          end
          win_d[7] = new_w;
          if (variant_q == VARIANT_128) begin
            win_d[3] = new_w;
          end
          if (pos_q == pos_max) begin
            pos_d = 3'd0;
            rnd_d = rnd_q + 4'd1;
          end else begin
            pos_d = pos_q + 3'd1;
          end
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= 6'd0;
      pos_q       <= 3'd0;
      rnd_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Word window and output payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 8; k++) begin
      win_q[k] <= win_d[k];
    end
    if (adv) begin
      out_word_q <= win_q[0];
      out_idx_q  <= idx_q;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign round_key_word_o = out_word_q;
  assign word_index_o     = out_idx_q;
  assign last_word_o      = out_last_q;

  // Checks
`include "aes_key_schedule_128_256_assert.svh"

  `AKS_ASSERT(a_start_run, in_acc |=> (state_q == ST_RUN) && (idx_q == 6'd0), "key accept did not start schedule")
  `AKS_ASSERT(a_idx_range, (state_q == ST_RUN) |-> (idx_q <= LAST_IDX_256), "word index out of range")
  `AKS_ASSERT(a_last_idx, (out_valid_q && out_last_q) |-> ((out_idx_q == LAST_IDX_128) || (out_idx_q == LAST_IDX_256)), "last flag on wrong word")
  `AKS_ASSERT(a_last_idle, (adv && is_last) |=> (state_q == ST_IDLE) && out_valid_q, "sequencer did not stop after last word")
  `AKS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!out_valid_q && (state_q == ST_IDLE)), "output not empty in reset")

endmodule

`default_nettype wire
